FILE: hdl/c6502_pkg.sv
// ----------------------------------------------------------------------------
// c6502_pkg
// Shared types and constants for the 6502 execute unit: opcode classes,
// status flag positions, store targets and reset values.
// ----------------------------------------------------------------------------
package c6502_pkg;

  // Status flag bit positions (N V - B D I Z C)
  localparam logic [2:0] FLAG_N = 3'd7;
  localparam logic [2:0] FLAG_V = 3'd6;
  localparam logic [2:0] FLAG_B = 3'd4;
  localparam logic [2:0] FLAG_D = 3'd3;
  localparam logic [2:0] FLAG_I = 3'd2;
  localparam logic [2:0] FLAG_Z = 3'd1;
  localparam logic [2:0] FLAG_C = 3'd0;

  // Store target codes
  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_MEM   = 2'd1;
  localparam logic [1:0] ST_STACK = 2'd2;

  // Architectural reset values
  localparam logic [7:0] RESET_SP = 8'hFD;
  localparam logic [7:0] RESET_P  = 8'h24;

  typedef enum logic [5:0] {
    OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP, OP_SBC,
    OP_BRANCH, OP_BRK, OP_PHP, OP_PLP, OP_PHA, OP_PLA,
    OP_SEC, OP_SEI, OP_CLD, OP_ROLA, OP_ROLM, OP_INC,
    OP_STY, OP_STX, OP_LDY, OP_LDX, OP_CPY, OP_CPX,
    OP_DEY, OP_INY, OP_DEX, OP_INX,
    OP_TXA, OP_TYA, OP_TAX, OP_TAY, OP_TXS, OP_NOP, OP_BAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [2:0] br_bit;   // status bit tested by a branch
    logic       br_want;  // value of that bit that takes the branch
  } dec_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } arch_state_t;

  typedef struct packed {
    logic [1:0] store_target;
    logic [7:0] store_data;
    logic       branch_taken;
    logic [7:0] status;
    logic [7:0] stack_pointer;
    logic       bad_opcode;
  } result_t;

endpackage

FILE: hdl/c6502_decode.sv
// ----------------------------------------------------------------------------
// c6502_decode
// Opcode byte to instruction class and branch condition.
// ----------------------------------------------------------------------------
module c6502_decode (
  input  logic [7:0]       command,
  output c6502_pkg::dec_t  dec
);

  always_comb begin
    dec.kind    = c6502_pkg::OP_BAD;
    dec.br_bit  = c6502_pkg::FLAG_N;
    dec.br_want = command[5];

    if ((command[1:0] == 2'b01) && (command != 8'h89)) begin
      // Group one ALU column, every addressing mode
      case (command[7:5])
        3'd0:    dec.kind = c6502_pkg::OP_ORA;
        3'd1:    dec.kind = c6502_pkg::OP_AND;
        3'd2:    dec.kind = c6502_pkg::OP_EOR;
        3'd3:    dec.kind = c6502_pkg::OP_ADC;
        3'd4:    dec.kind = c6502_pkg::OP_STA;
        3'd5:    dec.kind = c6502_pkg::OP_LDA;
        3'd6:    dec.kind = c6502_pkg::OP_CMP;
        default: dec.kind = c6502_pkg::OP_SBC;
      endcase
    end else if (command[4:0] == 5'h10) begin
      dec.kind = c6502_pkg::OP_BRANCH;
      case (command[7:6])
        2'd0:    dec.br_bit = c6502_pkg::FLAG_N;
        2'd1:    dec.br_bit = c6502_pkg::FLAG_V;
        2'd2:    dec.br_bit = c6502_pkg::FLAG_C;
        default: dec.br_bit = c6502_pkg::FLAG_Z;
      endcase
    end else begin
      case (command)
        8'h00: dec.kind = c6502_pkg::OP_BRK;
        8'h08: dec.kind = c6502_pkg::OP_PHP;
        8'h28: dec.kind = c6502_pkg::OP_PLP;
        8'h48: dec.kind = c6502_pkg::OP_PHA;
        8'h68: dec.kind = c6502_pkg::OP_PLA;
        8'h38: dec.kind = c6502_pkg::OP_SEC;
        8'h78: dec.kind = c6502_pkg::OP_SEI;
        8'hD8: dec.kind = c6502_pkg::OP_CLD;
        8'h2A: dec.kind = c6502_pkg::OP_ROLA;
        8'h26, 8'h2E, 8'h36, 8'h3E: dec.kind = c6502_pkg::OP_ROLM;
        8'hE6, 8'hEE, 8'hF6, 8'hFE: dec.kind = c6502_pkg::OP_INC;
        8'h84, 8'h8C, 8'h94: dec.kind = c6502_pkg::OP_STY;
        8'h86, 8'h8E, 8'h96: dec.kind = c6502_pkg::OP_STX;
        8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: dec.kind = c6502_pkg::OP_LDY;
        8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: dec.kind = c6502_pkg::OP_LDX;
        8'hC0, 8'hC4, 8'hCC: dec.kind = c6502_pkg::OP_CPY;
        8'hE0, 8'hE4, 8'hEC: dec.kind = c6502_pkg::OP_CPX;
        8'h88: dec.kind = c6502_pkg::OP_DEY;
        8'hC8: dec.kind = c6502_pkg::OP_INY;
        8'hCA: dec.kind = c6502_pkg::OP_DEX;
        8'hE8: dec.kind = c6502_pkg::OP_INX;
        8'h8A: dec.kind = c6502_pkg::OP_TXA;
        8'h98: dec.kind = c6502_pkg::OP_TYA;
        8'hAA: dec.kind = c6502_pkg::OP_TAX;
        8'hA8: dec.kind = c6502_pkg::OP_TAY;
        8'h9A: dec.kind = c6502_pkg::OP_TXS;
        8'hEA: dec.kind = c6502_pkg::OP_NOP;
        default: dec.kind = c6502_pkg::OP_BAD;
      endcase
    end
  end

endmodule

FILE: hdl/c6502_exec.sv
// ----------------------------------------------------------------------------
// c6502_exec
// One-pass execute: next register file and status, store and branch result.
// ----------------------------------------------------------------------------
module c6502_exec (
  input  c6502_pkg::dec_t         dec,
  input  logic [7:0]              operand,
  input  c6502_pkg::arch_state_t  cur,
  output c6502_pkg::arch_state_t  nxt,
  output c6502_pkg::result_t      res
);

  logic [7:0] add_m;
  logic [8:0] sum9;
  logic       add_v;
  logic [7:0] cmp_reg;
  logic [8:0] cmp9;
  logic [7:0] rol_in;
  logic [7:0] rol_out;
  logic [7:0] inc_m;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[c6502_pkg::FLAG_N] = v[7];
    q[c6502_pkg::FLAG_Z] = (v == 8'd0);
    return q;
  endfunction

  // SBC is ADC of the inverted operand
  assign add_m = (dec.kind == c6502_pkg::OP_SBC) ? ~operand : operand;
  assign sum9  = {1'b0, cur.a} + {1'b0, add_m} + {8'd0, cur.p[c6502_pkg::FLAG_C]};
  assign add_v = (~(cur.a[7] ^ add_m[7])) & (cur.a[7] ^ sum9[7]);

  always_comb begin
    case (dec.kind)
      c6502_pkg::OP_CPX: cmp_reg = cur.x;
      c6502_pkg::OP_CPY: cmp_reg = cur.y;
      default:           cmp_reg = cur.a;
    endcase
  end

  // Carry out of reg + ~m + 1 is reg >= m
  assign cmp9    = {1'b0, cmp_reg} + {1'b0, ~operand} + 9'd1;
  assign rol_in  = (dec.kind == c6502_pkg::OP_ROLA) ? cur.a : operand;
  assign rol_out = {rol_in[6:0], cur.p[c6502_pkg::FLAG_C]};
  assign inc_m   = operand + 8'd1;

  always_comb begin
    nxt = cur;
    res = '0;
    case (dec.kind)
      c6502_pkg::OP_ORA: begin
        nxt.a = cur.a | operand;
        nxt.p = set_nz(cur.p, cur.a | operand);
      end
      c6502_pkg::OP_AND: begin
        nxt.a = cur.a & operand;
        nxt.p = set_nz(cur.p, cur.a & operand);
      end
      c6502_pkg::OP_EOR: begin
        nxt.a = cur.a ^ operand;
        nxt.p = set_nz(cur.p, cur.a ^ operand);
      end
      c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
        nxt.a = sum9[7:0];
        nxt.p = set_nz(cur.p, sum9[7:0]);
        nxt.p[c6502_pkg::FLAG_V] = add_v;
        nxt.p[c6502_pkg::FLAG_C] = sum9[8];
      end
      c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
        nxt.p = set_nz(cur.p, cmp9[7:0]);
        nxt.p[c6502_pkg::FLAG_C] = cmp9[8];
      end
      c6502_pkg::OP_STA: begin
        res.store_target = c6502_pkg::ST_MEM;
        res.store_data   = cur.a;
      end
      c6502_pkg::OP_STX: begin
        res.store_target = c6502_pkg::ST_MEM;
        res.store_data   = cur.x;
      end
      c6502_pkg::OP_STY: begin
        res.store_target = c6502_pkg::ST_MEM;
        res.store_data   = cur.y;
      end
      c6502_pkg::OP_LDA: begin
        nxt.a = operand;
        nxt.p = set_nz(cur.p, operand);
      end
      c6502_pkg::OP_LDX: begin
        nxt.x = operand;
        nxt.p = set_nz(cur.p, operand);
      end
      c6502_pkg::OP_LDY: begin
        nxt.y = operand;
        nxt.p = set_nz(cur.p, operand);
      end
      c6502_pkg::OP_BRANCH: begin
        res.branch_taken = (cur.p[dec.br_bit] == dec.br_want);
      end
      c6502_pkg::OP_BRK: nxt.p[c6502_pkg::FLAG_B] = 1'b1;
      c6502_pkg::OP_SEC: nxt.p[c6502_pkg::FLAG_C] = 1'b1;
      c6502_pkg::OP_SEI: nxt.p[c6502_pkg::FLAG_I] = 1'b1;
      c6502_pkg::OP_CLD: nxt.p[c6502_pkg::FLAG_D] = 1'b0;
      c6502_pkg::OP_PHP: begin
        res.store_target = c6502_pkg::ST_STACK;
        res.store_data   = cur.p;
        nxt.sp           = cur.sp - 8'd1;
      end
      c6502_pkg::OP_PHA: begin
        res.store_target = c6502_pkg::ST_STACK;
        res.store_data   = cur.a;
        nxt.sp           = cur.sp - 8'd1;
      end
      c6502_pkg::OP_PLP: begin
        nxt.sp = cur.sp + 8'd1;
        nxt.p  = operand;
      end
      c6502_pkg::OP_PLA: begin
        nxt.sp = cur.sp + 8'd1;
        nxt.a  = operand;
        nxt.p  = set_nz(cur.p, operand);
      end
      c6502_pkg::OP_ROLA: begin
        nxt.a = rol_out;
        nxt.p = set_nz(cur.p, rol_out);
        nxt.p[c6502_pkg::FLAG_C] = rol_in[7];
      end
      c6502_pkg::OP_ROLM: begin
        res.store_target = c6502_pkg::ST_MEM;
        res.store_data   = rol_out;
        nxt.p = set_nz(cur.p, rol_out);
        nxt.p[c6502_pkg::FLAG_C] = rol_in[7];
      end
      c6502_pkg::OP_INC: begin
        res.store_target = c6502_pkg::ST_MEM;
        res.store_data   = inc_m;
        nxt.p = set_nz(cur.p, inc_m);
      end
      c6502_pkg::OP_DEY: begin
        nxt.y = cur.y - 8'd1;
        nxt.p = set_nz(cur.p, cur.y - 8'd1);
      end
      c6502_pkg::OP_INY: begin
        nxt.y = cur.y + 8'd1;
        nxt.p = set_nz(cur.p, cur.y + 8'd1);
      end
      c6502_pkg::OP_DEX: begin
        nxt.x = cur.x - 8'd1;
        nxt.p = set_nz(cur.p, cur.x - 8'd1);
      end
      c6502_pkg::OP_INX: begin
        nxt.x = cur.x + 8'd1;
        nxt.p = set_nz(cur.p, cur.x + 8'd1);
      end
      c6502_pkg::OP_TXA: begin
        nxt.a = cur.x;
        nxt.p = set_nz(cur.p, cur.x);
      end
      c6502_pkg::OP_TYA: begin
        nxt.a = cur.y;
        nxt.p = set_nz(cur.p, cur.y);
      end
      c6502_pkg::OP_TAX: begin
        nxt.x = cur.a;
        nxt.p = set_nz(cur.p, cur.a);
      end
      c6502_pkg::OP_TAY: begin
        nxt.y = cur.a;
        nxt.p = set_nz(cur.p, cur.a);
      end
      c6502_pkg::OP_TXS: nxt.sp = cur.x;
      c6502_pkg::OP_NOP: ;
      default: res.bad_opcode = 1'b1;
    endcase
    res.status        = nxt.p;
    res.stack_pointer = nxt.sp;
  end

endmodule

FILE: hdl/cpu_6502_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu_6502_execute_unit
// 6502 instruction execute stage: register file, status and stack pointer.
// ----------------------------------------------------------------------------
// Each request carries one opcode byte and the data byte that instruction
// reads (immediate, memory or pulled stack byte). The unit sustains one
// instruction per clock unless the output stalls: a request is captured in an
// input register, runs through a single decode and execute pass (short 8-bit
// adders and flag logic) and enters the result register once it is free. A,
// X, Y, SP and P are written in the same cycle the result is registered, so
// the next instruction sees them with no bubble. Decimal mode, address
// generation and the program counter live outside; unimplemented opcodes
// return bad_opcode with no state change. After reset SP = 0xFD and P = 0x24.
// ----------------------------------------------------------------------------
module cpu_6502_execute_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] command, [15:8] operand

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata    // [1:0] store_target, [9:2] store_data,
                                   // [10] branch_taken, [18:11] status,
                                   // [26:19] stack_pointer, [27] bad_opcode,
                                   // [31:28] zero
);

  logic                   in_valid_r;
  logic [7:0]             cmd_r;
  logic [7:0]             opnd_r;
  logic                   out_valid_r;
  c6502_pkg::result_t     res_r;
  c6502_pkg::result_t     res_nxt;
  c6502_pkg::arch_state_t state_r;
  c6502_pkg::arch_state_t state_nxt;
  c6502_pkg::dec_t        dec;
  logic                   adv;

  // Advance the held request into the result register when that slot is free
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  c6502_decode u_decode (
    .command (cmd_r),
    .dec     (dec)
  );

  c6502_exec u_exec (
    .dec     (dec),
    .operand (opnd_r),
    .cur     (state_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r.a   <= 8'd0;
      state_r.x   <= 8'd0;
      state_r.y   <= 8'd0;
      state_r.sp  <= c6502_pkg::RESET_SP;
      state_r.p   <= c6502_pkg::RESET_P;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tdata[7:0];
      opnd_r <= in_tdata[15:8];
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.bad_opcode, res_r.stack_pointer, res_r.status,
                       res_r.branch_taken, res_r.store_data, res_r.store_target};

  // An empty result slot never blocks intake
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // A rejected opcode leaves no store and no branch
  a_bad_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.bad_opcode) |->
      (res_r.store_target == c6502_pkg::ST_NONE) && !res_r.branch_taken)
    else $error("bad opcode produced a store or branch");

  // A rejected opcode changes no architectural state
  a_bad_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_nxt.bad_opcode) |=> $stable(state_r))
    else $error("bad opcode changed state");

  // A push reports the stack pointer one below the slot written
  a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (res_nxt.store_target == c6502_pkg::ST_STACK)) |=>
      (res_r.stack_pointer == ($past(state_r.sp) - 8'd1)))
    else $error("push did not decrement the stack pointer");

  // Reported status and stack pointer track the live registers
  a_status_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (res_r.status == state_r.p) && (res_r.stack_pointer == state_r.sp))
    else $error("result status out of step with state");

endmodule
